[src/dsi_pkg.sv]
// Shared types and codes for the drive safety interlock.
// No dependencies; used by the channel interfaces, the top level and the checker.
package dsi_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgIdxW = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ARMED_TIMEOUT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_STOPPING_CAP  = 1'd1;

  localparam logic [TimeW-1:0] ARMED_TIMEOUT_RST = 32'd30000;
  localparam logic [TimeW-1:0] STOPPING_CAP_RST  = 32'd3000;

  // drive_mode codes as seen on the result channel
  localparam logic [2:0] MODE_SAFE     = 3'd0;
  localparam logic [2:0] MODE_ARMED    = 3'd1;
  localparam logic [2:0] MODE_DRIVE    = 3'd2;
  localparam logic [2:0] MODE_STOPPING = 3'd3;
  localparam logic [2:0] MODE_FAULT    = 3'd4;

  // fault_code values
  localparam logic [2:0] FC_NONE        = 3'd0;
  localparam logic [2:0] FC_WHEEL_LOST  = 3'd1;
  localparam logic [2:0] FC_STEER_LINK  = 3'd2;
  localparam logic [2:0] FC_STEER_FAULT = 3'd3;
  localparam logic [2:0] FC_PEDAL       = 3'd4;
  localparam logic [2:0] FC_DAC         = 3'd5;

  // health_flags bit positions
  localparam int unsigned HF_WHEEL_OK  = 0;
  localparam int unsigned HF_STEER_OK  = 1;
  localparam int unsigned HF_STEER_ERR = 2;
  localparam int unsigned HF_PEDAL_OK  = 3;
  localparam int unsigned HF_DAC_OK    = 4;

  typedef enum logic [4:0] {
    ST_SAFE     = 5'b00001,
    ST_ARMED    = 5'b00010,
    ST_DRIVE    = 5'b00100,
    ST_STOPPING = 5'b01000,
    ST_FAULT    = 5'b10000
  } dsi_state_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic [4:0]       health_flags;
    logic             arm_confirm;
    logic             steer_cal_done;
    logic             vehicle_stopped;
    logic             throttle_at_zero;
    logic             disarm_req;
    logic             drive_req;
    logic             clear_req;
  } dsi_in_t;

  typedef struct packed {
    logic [2:0] drive_mode;
    logic [2:0] fault_code;
    logic       contactor_on;
    logic       steer_en;
    logic       throttle_en;
    logic       brake_on;
  } dsi_out_t;

  // Priority encoder: first failing check wins
  function automatic logic [2:0] health_code(input logic [4:0] flags);
    logic [2:0] hc;
    hc = FC_NONE;
    if (!flags[HF_WHEEL_OK])      hc = FC_WHEEL_LOST;
    else if (!flags[HF_STEER_OK]) hc = FC_STEER_LINK;
    else if (flags[HF_STEER_ERR]) hc = FC_STEER_FAULT;
    else if (!flags[HF_PEDAL_OK]) hc = FC_PEDAL;
    else if (!flags[HF_DAC_OK])   hc = FC_DAC;
    return hc;
  endfunction

  function automatic logic [2:0] mode_code(input dsi_state_t st);
    logic [2:0] m;
    unique case (st)
      ST_ARMED:    m = MODE_ARMED;
      ST_DRIVE:    m = MODE_DRIVE;
      ST_STOPPING: m = MODE_STOPPING;
      ST_FAULT:    m = MODE_FAULT;
      default:     m = MODE_SAFE;
    endcase
    return m;
  endfunction

endpackage

[src/dsi_in_if.sv]
// Tick channel into the interlock: valid/ready plus one dsi_in_t payload.
// Depends on dsi_pkg.
interface dsi_in_if
  import dsi_pkg::*;
  ();
  logic    valid;
  logic    ready;
  dsi_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/dsi_out_if.sv]
// Result channel out of the interlock: valid/ready plus one dsi_out_t payload.
// Depends on dsi_pkg.
interface dsi_out_if
  import dsi_pkg::*;
  ();
  logic     valid;
  logic     ready;
  dsi_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/drive_safety_interlock_fsm_top.sv]
// Drive safety interlock, top level. One tick transaction in, one result
// transaction out, through the input register and then the result register;
// a new tick is taken every cycle as long as the result side keeps draining, so
// the sustained rate is one transaction per cycle. That rate is set by the single
// combinational pass from the tick register through the state update (one 32-bit
// subtract-and-compare per timer) into the result register. Configuration writes
// go straight into the two timer registers and take effect for the next tick.
// Depends on dsi_pkg, dsi_in_if and dsi_out_if.
module drive_safety_interlock_fsm_top
  import dsi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  dsi_in_if.sink             in_chan,
  dsi_out_if.source          out_chan,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [TimeW-1:0]   cfg_wdata
);

  // Config registers
  logic [TimeW-1:0] armed_timeout_r;
  logic [TimeW-1:0] stopping_cap_r;

  // Tick register (stage 1)
  logic    tick_vld_r;
  dsi_in_t tick_r;

  // Interlock state
  dsi_state_t       state_r, state_nxt;
  logic [2:0]       pend_r, pend_nxt;
  logic [2:0]       latch_r, latch_nxt;
  logic [TimeW-1:0] arm_t_r, arm_t_nxt;
  logic [TimeW-1:0] stop_t_r, stop_t_nxt;

  // Result register (stage 2)
  logic     out_vld_r;
  dsi_out_t out_r, out_nxt;

  logic             advance;
  logic [2:0]       hc;
  logic [2:0]       pend_eff;
  logic [TimeW-1:0] arm_elapsed;
  logic [TimeW-1:0] stop_elapsed;
  logic             stop_done;

  // Tick moves to the result register when the result slot is free or draining.
  assign advance       = tick_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !tick_vld_r || advance;

  assign out_chan.valid = out_vld_r;
  assign out_chan.data  = out_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_timeout_r <= ARMED_TIMEOUT_RST;
      stopping_cap_r  <= STOPPING_CAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ARMED_TIMEOUT: armed_timeout_r <= cfg_wdata;
        CFG_STOPPING_CAP:  stopping_cap_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      tick_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      tick_r <= in_chan.data;
    end
  end

  // ---------------------------------------------------------------- next state
  assign hc           = health_code(tick_r.health_flags);
  // Elapsed times wrap modulo 2^32 by construction of the 32-bit subtract.
  assign arm_elapsed  = tick_r.now_ms - arm_t_r;
  assign stop_elapsed = tick_r.now_ms - stop_t_r;
  // A health failure during a plain stop upgrades it to a fault stop.
  assign pend_eff     = (pend_r == FC_NONE) ? hc : pend_r;
  assign stop_done    = tick_r.vehicle_stopped || (stop_elapsed >= stopping_cap_r);

  always_comb begin
    state_nxt  = state_r;
    pend_nxt   = pend_r;
    latch_nxt  = latch_r;
    arm_t_nxt  = arm_t_r;
    stop_t_nxt = stop_t_r;

    unique case (state_r)
      ST_ARMED: begin
        if (hc != FC_NONE) begin
          state_nxt  = ST_STOPPING;
          pend_nxt   = hc;
          stop_t_nxt = tick_r.now_ms;
        end else if (tick_r.disarm_req || (arm_elapsed >= armed_timeout_r)) begin
          // manual disarm or armed timeout: plain stop, latched only if a health failure upgrades it
          state_nxt  = ST_STOPPING;
          pend_nxt   = FC_NONE;
          stop_t_nxt = tick_r.now_ms;
        end else if (tick_r.drive_req && tick_r.throttle_at_zero) begin
          state_nxt = ST_DRIVE;
        end
      end
      ST_DRIVE: begin
        if (hc != FC_NONE) begin
          state_nxt  = ST_STOPPING;
          pend_nxt   = hc;
          stop_t_nxt = tick_r.now_ms;
        end else if (tick_r.disarm_req) begin
          state_nxt  = ST_STOPPING;
          pend_nxt   = FC_NONE;
          stop_t_nxt = tick_r.now_ms;
        end
      end
      ST_STOPPING: begin
        pend_nxt = pend_eff;
        if (stop_done) begin
          if (pend_eff != FC_NONE) begin
            latch_nxt = pend_eff;
            pend_nxt  = FC_NONE;
            state_nxt = ST_FAULT;
          end else begin
            state_nxt = ST_SAFE;
          end
        end
      end
      ST_FAULT: begin
        if (tick_r.clear_req && tick_r.vehicle_stopped && (hc == FC_NONE)) begin
          latch_nxt = FC_NONE;
          state_nxt = ST_SAFE;
        end
      end
      default: begin
        if (tick_r.arm_confirm && (hc == FC_NONE) && tick_r.steer_cal_done &&
            tick_r.vehicle_stopped && tick_r.throttle_at_zero) begin
          arm_t_nxt = tick_r.now_ms;
          state_nxt = ST_ARMED;
        end else begin
          state_nxt = ST_SAFE;
        end
      end
    endcase
  end

  // Result fields from the updated state
  always_comb begin
    out_nxt.drive_mode   = mode_code(state_nxt);
    out_nxt.fault_code   = FC_NONE;
    out_nxt.contactor_on = 1'b0;
    out_nxt.throttle_en  = 1'b0;
    out_nxt.brake_on     = 1'b0;
    unique case (state_nxt)
      ST_ARMED: begin
        out_nxt.contactor_on = 1'b1;
      end
      ST_DRIVE: begin
        out_nxt.contactor_on = 1'b1;
        out_nxt.throttle_en  = 1'b1;
      end
      ST_STOPPING: begin
        out_nxt.contactor_on = 1'b1;
        out_nxt.brake_on     = 1'b1;
        out_nxt.fault_code   = pend_nxt;
      end
      ST_FAULT: begin
        out_nxt.fault_code = latch_nxt;
      end
      default: ;
    endcase
    out_nxt.steer_en = out_nxt.contactor_on;
  end

  // ---------------------------------------------------------------- state and stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_SAFE;
      pend_r   <= FC_NONE;
      latch_r  <= FC_NONE;
      arm_t_r  <= '0;
      stop_t_r <= '0;
    end else if (advance) begin
      state_r  <= state_nxt;
      pend_r   <= pend_nxt;
      latch_r  <= latch_nxt;
      arm_t_r  <= arm_t_nxt;
      stop_t_r <= stop_t_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

endmodule

[src/dsi_checker.sv]
// Port-level checks for the drive safety interlock, bound to the top level.
// Depends on dsi_pkg and drive_safety_interlock_fsm_top.
module dsi_checker
  import dsi_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input dsi_out_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Nothing leaves right after reset.
  a_rst_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // Once an accepted tick has gone through the tick register, a result must be valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("accepted tick produced no result");

  // A fault code shows only in stopping or fault, and fault always carries one.
  a_code_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.fault_code == FC_NONE) ||
                   (out_data.drive_mode == MODE_STOPPING) ||
                   (out_data.drive_mode == MODE_FAULT)) &&
                  ((out_data.drive_mode != MODE_FAULT) ||
                   (out_data.fault_code != FC_NONE)))
    else $error("fault code inconsistent with mode");

endmodule

bind drive_safety_interlock_fsm_top dsi_checker u_dsi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);
